// ----- sv/pns_pkg.sv -----
`default_nettype none
package pns_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_DETECTOR_MODE = 3'd0;
    localparam logic [2:0] REG_BIAS_LEVEL    = 3'd1;
    localparam logic [2:0] REG_GAIN          = 3'd2;
    localparam logic [2:0] REG_READ_NOISE    = 3'd3;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int BIAS_W      = 20;
    localparam int GAIN_W      = 16;
    localparam int RN_W        = 16;
    localparam int SIGMA_W     = 24;
    localparam int M_TDATA_W   = 32;

    localparam logic [SIGMA_W-1:0] SIGMA_MAX = 24'hFFFFFF;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd4096;

    // Per-word flags that ride along the cell chain
    typedef struct packed {
        logic use_rn;     // CCD word with no positive signal: divide read noise
        logic force_sat;  // CCD word with zero gain
    } pns_flags_t;

endpackage
`default_nettype wire

// ----- sv/pns_sqrt_cell.sv -----
`default_nettype none
module pns_sqrt_cell #(
    parameter int RB = 32
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     valid_in,
    output logic                    ready_out,
    input  wire pns_pkg::pns_flags_t flags_in,
    input  wire [2*RB-1:0]          rad_in,
    input  wire [RB+3:0]            rem_in,
    input  wire [RB-1:0]            root_in,
    output logic                    valid_out,
    input  wire                     ready_in,
    output pns_pkg::pns_flags_t     flags_out,
    output logic [2*RB-1:0]         rad_out,
    output logic [RB+3:0]           rem_out,
    output logic [RB-1:0]           root_out
);
    import pns_pkg::*;

    localparam int RW   = 2 * RB;
    localparam int REMW = RB + 4;

    logic            valid_reg;
    pns_flags_t      flags_reg;
    logic [RW-1:0]   rad_reg;
    logic [REMW-1:0] rem_reg;
    logic [RB-1:0]   root_reg;

    logic [REMW-1:0] t;
    logic [REMW-1:0] trial;
    logic            ge;

    // One root digit: bring down the next pair, try {root, 01}
    always_comb begin
        t     = {rem_in[REMW-3:0], rad_in[RW-1 -: 2]};
        trial = REMW'({root_in, 2'b01});
        ge    = (t >= trial);
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_out) begin
            valid_reg <= valid_in;
        end
        if (ready_out && valid_in) begin
            flags_reg <= flags_in;
            rad_reg   <= {rad_in[RW-3:0], 2'b00};
            rem_reg   <= ge ? (t - trial) : t;
            root_reg  <= {root_in[RB-2:0], ge};
        end
    end

    assign valid_out = valid_reg;
    assign flags_out = flags_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;

endmodule
`default_nettype wire

// ----- sv/pns_div_cell.sv -----
`default_nettype none
module pns_div_cell #(
    parameter int NB = 32
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire [15:0]              divisor,
    input  wire                     valid_in,
    output logic                    ready_out,
    input  wire pns_pkg::pns_flags_t flags_in,
    input  wire [NB-1:0]            nq_in,
    input  wire [15:0]              rem_in,
    output logic                    valid_out,
    input  wire                     ready_in,
    output pns_pkg::pns_flags_t     flags_out,
    output logic [NB-1:0]           nq_out,
    output logic [15:0]             rem_out
);
    import pns_pkg::*;

    logic          valid_reg;
    pns_flags_t    flags_reg;
    logic [NB-1:0] nq_reg;
    logic [15:0]   rem_reg;

    logic [16:0] t;
    logic [16:0] diff;
    logic        ge;

    // Restoring step: numerator bits shift out the top, quotient bits in at the bottom
    always_comb begin
        t    = {rem_in, nq_in[NB-1]};
        ge   = (t >= {1'b0, divisor});
        diff = t - {1'b0, divisor};
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_out) begin
            valid_reg <= valid_in;
        end
        if (ready_out && valid_in) begin
            flags_reg <= flags_in;
            nq_reg    <= {nq_in[NB-2:0], ge};
            rem_reg   <= ge ? diff[15:0] : t[15:0];
        end
    end

    assign valid_out = valid_reg;
    assign flags_out = flags_reg;
    assign nq_out    = nq_reg;
    assign rem_out   = rem_reg;

endmodule
`default_nettype wire

// ----- sv/pixel_noise_sigma.sv -----
// Structure, with RB = (PIXEL_WIDTH + 42) / 2: one prep stage, RB square-root cells,
// RB divider cells, one output register. Throughput: one word per cycle while m_tready holds;
// every cell takes a new word each cycle unless the stage after it stalls.
// Reset (aresetn low, synchronous) empties all stages and loads detector_mode = 0,
// bias_level = 0, gain = 4096, read_noise = 0.
`default_nettype none
module pixel_noise_sigma #(
    parameter int PIXEL_WIDTH = 22
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // configuration write port
    input  wire                              cfg_we,
    input  wire [pns_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [pns_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream; tdata: pixel_value
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [((PIXEL_WIDTH+7)/8)*8-1:0]  s_tdata,
    // result stream; tdata: sigma [23:0], saturated [24]
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [pns_pkg::M_TDATA_W-1:0]    m_tdata
);
    import pns_pkg::*;

    localparam int PW = PIXEL_WIDTH;
    // d = pixel - bias, signed, wide enough for either operand
    localparam int DW = ((PW > BIAS_W) ? PW : BIAS_W) + 2;
    // S = d*gain + read_noise^2
    localparam int SW = PW + 17;
    // root digits; radicand is S << 24, padded to an even width
    localparam int RB = (SW + 25) / 2;
    localparam int RW = 2 * RB;

    // ---------------- configuration registers ----------------
    logic              mode_reg;
    logic [BIAS_W-1:0] bias_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [RN_W-1:0]   rn_reg;
    logic [2*RN_W-1:0] rn2_reg;   // read_noise squared, formed at write time

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            bias_reg <= '0;
            gain_reg <= GAIN_RESET;
            rn_reg   <= '0;
            rn2_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DETECTOR_MODE: mode_reg <= cfg_wdata[0];
                REG_BIAS_LEVEL:    bias_reg <= cfg_wdata[BIAS_W-1:0];
                REG_GAIN:          gain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_READ_NOISE: begin
                    rn_reg  <= cfg_wdata[RN_W-1:0];
                    rn2_reg <= cfg_wdata[RN_W-1:0] * cfg_wdata[RN_W-1:0];
                end
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ---------------- prep stage ----------------
    // Form the radicand and per-word flags; one subtract, one multiply and one add.
    logic signed [PW-1:0] pix;
    logic signed [DW-1:0] d;
    logic                 pix_pos;
    logic                 d_pos;
    logic [PW+15:0]       prod;
    logic [SW-1:0]        s_sum;
    logic [RW-1:0]        rad_next;
    pns_flags_t           flags_next;

    always_comb begin
        pix     = s_tdata[PW-1:0];
        d       = {{(DW-PW){pix[PW-1]}}, pix} - $signed({{(DW-BIAS_W){1'b0}}, bias_reg});
        pix_pos = !pix[PW-1] && (pix != '0);
        d_pos   = !d[DW-1] && (d != '0);
        // a positive d never exceeds the pixel, so its low PW bits hold it
        prod    = d[PW-1:0] * gain_reg;
        s_sum   = SW'(prod) + SW'(rn2_reg);
        if (mode_reg) begin
            rad_next = pix_pos ? RW'({pix[PW-2:0], 12'd0}) : '0;
        end else begin
            rad_next = d_pos ? RW'({s_sum, 24'd0}) : '0;
        end
        flags_next.use_rn    = !mode_reg && !d_pos;
        flags_next.force_sat = !mode_reg && (gain_reg == '0);
    end

    logic          p_valid_reg;
    pns_flags_t    p_flags_reg;
    logic [RW-1:0] p_rad_reg;

    // ---------------- cell chain wiring ----------------
    logic              sv_v   [0:RB];
    logic              sv_r   [0:RB];
    pns_flags_t        sv_f   [0:RB];
    logic [RW-1:0]     sv_rad [0:RB];
    logic [RB+3:0]     sv_rem [0:RB];
    logic [RB-1:0]     sv_rt  [0:RB];

    logic              dv_v   [0:RB];
    logic              dv_r   [0:RB];
    pns_flags_t        dv_f   [0:RB];
    logic [RB-1:0]     dv_nq  [0:RB];
    logic [15:0]       dv_rem [0:RB];

    logic [GAIN_W-1:0] divisor;

    assign s_tready = !p_valid_reg || sv_r[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            p_flags_reg <= flags_next;
            p_rad_reg   <= rad_next;
        end
    end

    assign sv_v[0]   = p_valid_reg;
    assign sv_f[0]   = p_flags_reg;
    assign sv_rad[0] = p_rad_reg;
    assign sv_rem[0] = '0;
    assign sv_rt[0]  = '0;

    // square root: one root bit per cell
    for (genvar i = 0; i < RB; i++) begin : g_sqrt
        pns_sqrt_cell #(.RB(RB)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .valid_in  (sv_v[i]),
            .ready_out (sv_r[i]),
            .flags_in  (sv_f[i]),
            .rad_in    (sv_rad[i]),
            .rem_in    (sv_rem[i]),
            .root_in   (sv_rt[i]),
            .valid_out (sv_v[i+1]),
            .ready_in  (sv_r[i+1]),
            .flags_out (sv_f[i+1]),
            .rad_out   (sv_rad[i+1]),
            .rem_out   (sv_rem[i+1]),
            .root_out  (sv_rt[i+1])
        );
    end

    // Pick the numerator: root of S, or read_noise in Q.12 for a non-positive signal.
    // Photon counting divides by one.
    assign divisor   = mode_reg ? GAIN_W'(1) : gain_reg;
    assign dv_v[0]   = sv_v[RB];
    assign sv_r[RB]  = dv_r[0];
    assign dv_f[0]   = sv_f[RB];
    assign dv_nq[0]  = sv_f[RB].use_rn ? RB'({rn_reg, 12'd0}) : sv_rt[RB];
    assign dv_rem[0] = '0;

    // divider: one quotient bit per cell
    for (genvar j = 0; j < RB; j++) begin : g_div
        pns_div_cell #(.NB(RB)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .divisor   (divisor),
            .valid_in  (dv_v[j]),
            .ready_out (dv_r[j]),
            .flags_in  (dv_f[j]),
            .nq_in     (dv_nq[j]),
            .rem_in    (dv_rem[j]),
            .valid_out (dv_v[j+1]),
            .ready_in  (dv_r[j+1]),
            .flags_out (dv_f[j+1]),
            .nq_out    (dv_nq[j+1]),
            .rem_out   (dv_rem[j+1])
        );
    end

    // ---------------- output register ----------------
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 sat;
    logic [SIGMA_W-1:0]   sigma;

    // clip at the maximum; zero gain always clips in CCD mode
    always_comb begin
        sat   = dv_f[RB].force_sat || (dv_nq[RB] >= RB'(SIGMA_MAX));
        sigma = sat ? SIGMA_MAX : dv_nq[RB][SIGMA_W-1:0];
    end

    assign dv_r[RB] = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dv_r[RB]) begin
            m_valid_reg <= dv_v[RB];
        end
        if (dv_r[RB] && dv_v[RB]) begin
            m_data_reg <= M_TDATA_W'({sat, sigma});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- assertions ----------------
    a_sat_means_max : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[SIGMA_W] |-> (m_tdata[SIGMA_W-1:0] == SIGMA_MAX))
        else $error("saturated word without maximum sigma");

    a_reset_empties : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !p_valid_reg)
        else $error("pipeline not empty after reset");

    a_prep_free_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        !p_valid_reg |-> s_tready)
        else $error("input stalled with empty prep stage");

    a_out_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

endmodule
`default_nettype wire
